// ===== design/rhp_pkg.sv =====
`default_nettype none
package rhp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  localparam int VEC_W            = 28;
  localparam int CFG_W            = 13;
  localparam logic [CFG_W-1:0] DISPLAY_RESET = 13'd256;

  localparam logic [16:0] SQRT3_Q16    = 17'd113512;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  // ceil(2^31 / 255), exact floor division by 255 for values below 2^23
  localparam logic [23:0] RECIP_255    = 24'd8421505;
  localparam int          RECIP_SHIFT  = 31;

  typedef enum logic [0:0] {
    REG_DISPLAY_WIDTH  = 1'b0,
    REG_DISPLAY_HEIGHT = 1'b1
  } cfg_reg_t;

  // item as it moves along the row of cordic cells
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [31:0]             angle;
    logic                    grey;
    logic [15:0]             rem;
    logic [7:0]              den;
    logic [7:0]              quo;
    logic                    white;
  } cell_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/rhp_if.sv =====
`default_nettype none
interface rhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue_turn;
  logic [15:0] strength;
  logic [7:0]  darkness;
  logic [11:0] pos_x;
  logic [12:0] pos_y;
  modport source (output valid, hue_turn, strength, darkness, pos_x, pos_y, input ready);
  modport sink   (input valid, hue_turn, strength, darkness, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

// ===== design/rgb_to_hue_picker_position.sv =====
`default_nettype none
// rgb to hue picker position: takes one 8-bit rgb triple per request and returns hue (q0.16
// turn), strength (q1.15), darkness and the picker column and row. the block is a plain
// pipeline: one input stage, a row of CORDIC_STEPS cordic cells (the first eight of them also
// run one bit each of the darkness division), then four post stages for rounding, scaling and
// the picker products. it takes one request per cycle unless the output stalls; a result
// passes the input stage, cordic row and post stages in turn. each stage has its own valid
// and a ready chain, so bubbles close up under output stalls. the user must write display width
// and height on the cfg port only while no request is in flight; the block does not enforce it.
module rgb_to_hue_picker_position #(
  parameter int CORDIC_STEPS = rhp_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  rhp_in_if.sink                         in_chan,
  rhp_out_if.source                      out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [rhp_pkg::CFG_W-1:0] cfg_data
);

  // configuration registers
  logic [rhp_pkg::CFG_W-1:0] disp_w_r, disp_h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r <= rhp_pkg::DISPLAY_RESET;
      disp_h_r <= rhp_pkg::DISPLAY_RESET;
    end else if (cfg_we) begin
      case (rhp_pkg::cfg_reg_t'(cfg_index))
        rhp_pkg::REG_DISPLAY_WIDTH:  disp_w_r <= cfg_data;
        rhp_pkg::REG_DISPLAY_HEIGHT: disp_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: doubled hue vector, left half plane folded by half a turn,
  // darkness numerator and divisor from min and max
  logic signed [10:0]            dx;
  logic signed [8:0]             dy;
  logic signed [rhp_pkg::VEC_W-1:0] x0, y0;
  logic [7:0]                    mn, mx, span;
  rhp_pkg::cell_t                pre_nxt;

  always_comb begin
    dx = 11'(signed'({1'b0, in_chan.red, 1'b0})) - 11'(signed'({1'b0, in_chan.green}))
         - 11'(signed'({1'b0, in_chan.blue}));
    dy = signed'({1'b0, in_chan.green}) - signed'({1'b0, in_chan.blue});
    x0 = rhp_pkg::VEC_W'(dx) <<< 16;
    y0 = rhp_pkg::VEC_W'(dy) * signed'({1'b0, rhp_pkg::SQRT3_Q16});
    mn = (in_chan.red < in_chan.green) ? in_chan.red : in_chan.green;
    if (in_chan.blue < mn) mn = in_chan.blue;
    mx = (in_chan.red > in_chan.green) ? in_chan.red : in_chan.green;
    if (in_chan.blue > mx) mx = in_chan.blue;
    span = mx - mn;
    pre_nxt.grey  = (dx == 11'sd0) && (dy == 9'sd0);
    if (x0[rhp_pkg::VEC_W-1]) begin
      pre_nxt.x     = -x0;
      pre_nxt.y     = -y0;
      pre_nxt.angle = 32'h8000_0000;
    end else begin
      pre_nxt.x     = x0;
      pre_nxt.y     = y0;
      pre_nxt.angle = 32'd0;
    end
    pre_nxt.rem   = {span, 8'd0} - {8'd0, span};
    pre_nxt.den   = 8'd255 - mn;
    pre_nxt.quo   = 8'd0;
    pre_nxt.white = (mn == 8'd255);
  end

  // cordic row: index 0 is the input stage register, index k+1 the output of cell k
  logic           ch_v   [0:CORDIC_STEPS];
  logic           ch_rdy [0:CORDIC_STEPS];
  rhp_pkg::cell_t ch_d   [0:CORDIC_STEPS];

  logic           pre_v_r;
  rhp_pkg::cell_t pre_d_r;
  assign in_chan.ready = !pre_v_r || ch_rdy[0];
  assign ch_v[0]       = pre_v_r;
  assign ch_d[0]       = pre_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      pre_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      pre_d_r <= pre_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      rhp_cell #(.IDX(k)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ch_v[k]),
        .in_ready  (ch_rdy[k]),
        .in_data   (ch_d[k]),
        .out_valid (ch_v[k+1]),
        .out_ready (ch_rdy[k+1]),
        .out_data  (ch_d[k+1])
      );
    end
  endgenerate

  // rounding, saturation and picker scaling
  rhp_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .disp_w   (disp_w_r),
    .disp_h   (disp_h_r),
    .in_valid (ch_v[CORDIC_STEPS]),
    .in_ready (ch_rdy[CORDIC_STEPS]),
    .in_data  (ch_d[CORDIC_STEPS]),
    .out_chan (out_chan)
  );

  // strength never passes one
  a_strength_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.strength <= 16'd32768)
    else $error("strength above one");

  // no darkness puts the marker on the bottom row
  a_row_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.darkness == 8'd0) |-> out_chan.pos_y == disp_h_r)
    else $error("row for zero darkness is not the display height");

  // at zero strength, a zero hue puts the marker in column zero
  a_dark_no_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.strength == 16'd0) |-> out_chan.pos_x == 12'd0 ||
      out_chan.hue_turn != 16'd0)
    else $error("column nonzero at zero hue");

endmodule
`default_nettype wire

// ===== design/rhp_cell.sv =====
`default_nettype none
module rhp_cell #(
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rhp_pkg::cell_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rhp_pkg::cell_t      out_data
);

  logic           v_r;
  rhp_pkg::cell_t d_r, d_nxt;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_comb begin
    d_nxt = in_data;
    // one vectoring step, rotate toward the x axis
    if (!in_data.y[rhp_pkg::VEC_W-1]) begin
      d_nxt.x     = in_data.x + (in_data.y >>> IDX);
      d_nxt.y     = in_data.y - (in_data.x >>> IDX);
      d_nxt.angle = in_data.angle + rhp_pkg::atan_turn(5'(IDX));
    end else begin
      d_nxt.x     = in_data.x - (in_data.y >>> IDX);
      d_nxt.y     = in_data.y + (in_data.x >>> IDX);
      d_nxt.angle = in_data.angle - rhp_pkg::atan_turn(5'(IDX));
    end
  end

  // first eight cells also take one restoring step of the darkness quotient
  rhp_pkg::cell_t q_nxt;
  generate
    if (IDX < 8) begin : g_div
      localparam int SH = 7 - IDX;
      logic [15:0] dsh;
      always_comb begin
        q_nxt = d_nxt;
        dsh   = {8'd0, in_data.den} << SH;
        if (in_data.rem >= dsh) begin
          q_nxt.rem     = in_data.rem - dsh;
          q_nxt.quo[SH] = 1'b1;
        end
      end
    end else begin : g_nodiv
      always_comb q_nxt = d_nxt;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/rhp_post.sv =====
`default_nettype none
module rhp_post (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [rhp_pkg::CFG_W-1:0] disp_w,
  input  wire logic [rhp_pkg::CFG_W-1:0] disp_h,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire rhp_pkg::cell_t           in_data,
  rhp_out_if.source                     out_chan
);

  // stage 1: hue, strength product, darkness
  logic        v1_r;
  logic [15:0] hue1_r;
  logic [56:0] sp1_r;
  logic [7:0]  dk1_r;
  // stage 2: rounded strength, picker products
  logic        v2_r;
  logic [15:0] hue2_r;
  logic [25:0] su2_r;
  logic [7:0]  dk2_r;
  logic [28:0] px2_r;
  logic [20:0] py2_r;
  // stage 3: reciprocal multiplies
  logic        v3_r;
  logic [15:0] hue3_r;
  logic        ssat3_r;
  logic [46:0] sq3_r;
  logic [7:0]  dk3_r;
  logic [28:0] px3_r;
  logic [44:0] pyq3_r;
  // stage 4: output register
  logic        v4_r;
  logic [15:0] hue4_r, str4_r;
  logic [7:0]  dk4_r;
  logic [11:0] px4_r;
  logic [12:0] py4_r;

  logic rdy1, rdy2, rdy3, rdy4;
  assign rdy4     = !v4_r || out_chan.ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  logic [15:0] hue_nxt;
  logic [26:0] xs;
  logic [31:0] ang_rnd;
  logic [57:0] st;
  logic [15:0] sq_nxt;
  logic [12:0] px_sh;
  always_comb begin
    ang_rnd = in_data.angle + 32'h0000_8000;
    hue_nxt = in_data.grey ? 16'd0 : ang_rnd[31:16];
    xs = (in_data.grey || in_data.x[rhp_pkg::VEC_W-1]) ? 27'd0 : in_data.x[26:0];
    st     = {1'b0, sp1_r} + 58'(64'd255 << 31);
    sq_nxt = 16'(sq3_r >> rhp_pkg::RECIP_SHIFT);
    px_sh  = px3_r[28:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      hue1_r <= hue_nxt;
      sp1_r  <= 57'(xs) * 57'(rhp_pkg::INV_GAIN_Q30);
      dk1_r  <= in_data.white ? 8'd0 : in_data.quo;
    end
    if (v1_r && rdy2) begin
      hue2_r <= hue1_r;
      su2_r  <= st[57:32];
      dk2_r  <= dk1_r;
      px2_r  <= 29'(disp_w) * 29'(hue1_r);
      py2_r  <= 21'(8'd255 - dk1_r) * 21'(disp_h);
    end
    if (v2_r && rdy3) begin
      hue3_r  <= hue2_r;
      ssat3_r <= (su2_r[25:23] != 3'd0);
      sq3_r   <= 47'(su2_r[22:0]) * 47'(rhp_pkg::RECIP_255);
      dk3_r   <= dk2_r;
      px3_r   <= px2_r;
      pyq3_r  <= 45'(py2_r) * 45'(rhp_pkg::RECIP_255);
    end
    if (v3_r && rdy4) begin
      hue4_r <= hue3_r;
      str4_r <= (ssat3_r || sq_nxt > 16'd32768) ? 16'd32768 : sq_nxt;
      dk4_r  <= dk3_r;
      px4_r  <= px_sh[12] ? 12'd4095 : px_sh[11:0];
      py4_r  <= 13'(pyq3_r >> rhp_pkg::RECIP_SHIFT);
    end
  end

  assign out_chan.valid    = v4_r;
  assign out_chan.hue_turn = hue4_r;
  assign out_chan.strength = str4_r;
  assign out_chan.darkness = dk4_r;
  assign out_chan.pos_x    = px4_r;
  assign out_chan.pos_y    = py4_r;

endmodule
`default_nettype wire

// ===== verif/tb_hue_checker.sv =====
class hue_checker;
  int unsigned width_reg;
  int unsigned height_reg;
  logic [64:0] pending[$];
  int errors;

  function new();
    width_reg = 256;
    height_reg = 256;
    errors = 0;
  endfunction

  static function longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  static function logic [31:0] atan_entry(int i);
    int unsigned t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  // packed as hue, strength, darkness, x, y
  function logic [64:0] picker_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint x, y, dx, dy, mn, mx;
    logic [31:0] ang;
    logic [15:0] hue;
    longint unsigned str, dark, px, py, den;
    x = (2 * longint'(r) - g - b) * 65536;
    y = (longint'(g) - b) * 113512;
    ang = 0;
    hue = 0;
    str = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; ang += atan_entry(i);
        end else begin
          x -= dx; y += dy; ang -= atan_entry(i);
        end
      end
      hue = 16'((ang + 32'h8000) >> 16);
      den = 64'd2147483648 * 510;
      if (x > 0) str = (longint'(x) * 64'd652032874 + den / 2) / den;
      if (str > 32768) str = 32768;
    end
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    dark = (mn >= 255) ? 0 : ((mx - mn) * 255) / (255 - mn);
    px = (longint'(width_reg) * hue) >> 16;
    if (px > 4095) px = 4095;
    py = ((255 - dark) * height_reg) / 255;
    return {hue, 16'(str), 8'(dark), 12'(px), 13'(py)};
  endfunction

  function void note_request(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pending.push_back(picker_result(r, g, b));
  endfunction

  function void check_result(logic [64:0] got, time t);
    logic [64:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", t, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want !== got) begin
      $display("%0t: expected hue %0d str %0d dark %0d x %0d y %0d, got %0d %0d %0d %0d %0d",
        t, want[64:49], want[48:33], want[32:25], want[24:13], want[12:0],
        got[64:49], got[48:33], got[32:25], got[24:13], got[12:0]);
      errors++;
    end
  endfunction
endclass

// ===== verif/tb.sv =====
module tb;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [rhp_pkg::CFG_W-1:0] cfg_data;
  int unsigned cycles;
  bit quiet_in, quiet_out, sending_done;

  rhp_in_if in_chan ();
  rhp_out_if out_chan ();

  rgb_to_hue_picker_position dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hue_checker board = new();

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // generous limit: covers the whole pipeline plus heavy stalls on both sides
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, compare on every accepted result
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_result({out_chan.hue_turn, out_chan.strength, out_chan.darkness,
        out_chan.pos_x, out_chan.pos_y}, $time);
  end

  always @(negedge clk)
    out_chan.ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 18);

  // send one colour request, random gaps before it
  task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!quiet_in && $urandom_range(99) < 18) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.red <= r;
    in_chan.green <= g;
    in_chan.blue <= b;
    do @(posedge clk); while (!in_chan.ready);
    board.note_request(r, g, b);
    @(negedge clk);
  endtask

  // wait until nothing is in flight, then a few spare cycles
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(rhp_pkg::cfg_reg_t idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= rhp_pkg::CFG_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rhp_pkg::REG_DISPLAY_WIDTH) board.width_reg = v & 13'h1fff;
    else board.height_reg = v & 13'h1fff;
  endtask

  task automatic random_rgb();
    logic [7:0] r, g, b;
    int pick;
    pick = $urandom_range(9);
    r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
    // greys, a red channel at an edge, and equal green and blue now and then
    if (pick == 0) begin
      g = r; b = r;
    end else if (pick == 1) begin
      r = ($urandom_range(1)) ? 8'hff : 8'h00;
    end else if (pick == 2) begin
      b = g;
    end
    send_rgb(r, g, b);
  endtask

  initial begin
    int unsigned widths[6] = '{1, 4096, 256, 4095, 1000, 8191};
    int unsigned heights[6] = '{4096, 1, 256, 0, 777, 8191};
    rst_n = 0;
    cfg_we = 0;
    cfg_index = rhp_pkg::REG_DISPLAY_WIDTH;
    cfg_data = '0;
    cycles = 0;
    quiet_in = 0;
    quiet_out = 0;
    in_chan.valid = 0;
    in_chan.red = 0;
    in_chan.green = 0;
    in_chan.blue = 0;
    out_chan.ready = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: greys, white, black, primaries, secondaries, near-axis colours
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    send_rgb(255, 0, 1);
    send_rgb(254, 255, 255);
    send_rgb(0, 1, 0);
    send_rgb(170, 85, 85);
    send_rgb(1, 2, 3);
    drain();

    // sweep the display settings, extremes included; zero height too
    for (int s = 0; s < 6; s++) begin
      write_reg(rhp_pkg::REG_DISPLAY_WIDTH, widths[s]);
      write_reg(rhp_pkg::REG_DISPLAY_HEIGHT, heights[s]);
      if (s == 2) quiet_in = 1;
      if (s == 2) quiet_out = 1;
      for (int n = 0; n < 330; n++) begin
        random_rgb();
        // sender holds off until the pipe is empty
        if (n == 100) drain();
      end
      quiet_in = 0;
      quiet_out = 0;
      drain();
    end
    write_reg(rhp_pkg::REG_DISPLAY_WIDTH, 0);
    for (int n = 0; n < 20; n++) random_rgb();
    drain();

    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/rhp_pkg.sv
design/rhp_if.sv
design/rhp_cell.sv
design/rhp_post.sv
design/rgb_to_hue_picker_position.sv
verif/tb_hue_checker.sv
verif/tb.sv
